>>> hw/rtl/capi_b3_pkg.sv
package capi_b3_pkg;

  typedef enum logic [3:0] {
    M_CONN_REQ    = 4'd0,
    M_CONN_RESP   = 4'd1,
    M_ACTIVE_RESP = 4'd2,
    M_DISC_REQ    = 4'd3,
    M_DISC_RESP   = 4'd4,
    M_DATA_REQ    = 4'd5,
    M_DATA_RESP   = 4'd6,
    M_DL_DATA_IND = 4'd7,
    M_DL_DATA_CNF = 4'd8,
    M_DL_EST_IND  = 4'd9,
    M_DL_EST_CNF  = 4'd10,
    M_DL_REL_IND  = 4'd11,
    M_DL_REL_CNF  = 4'd12,
    M_DL_DOWN     = 4'd13,
    M_OTHER_REQ   = 4'd14,
    M_OTHER_RESP  = 4'd15
  } mode_t;

  typedef enum logic [3:0] {
    K_CONN_CONF   = 4'd0,
    K_CONN_IND    = 4'd1,
    K_ACTIVE_IND  = 4'd2,
    K_DISC_CONF   = 4'd3,
    K_DISC_IND    = 4'd4,
    K_DATA_IND    = 4'd5,
    K_DATA_CONF   = 4'd6,
    K_REJECT      = 4'd7,
    K_DL_EST_REQ  = 4'd8,
    K_DL_REL_REQ  = 4'd9,
    K_DL_DATA_REQ = 4'd10,
    K_RELEASE     = 4'd11,
    K_ERROR       = 4'd12
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE          = 3'd0,
    ST_CONNECTING    = 3'd1,
    ST_INCOMING      = 3'd2,
    ST_WAIT          = 3'd3,
    ST_ACTIVE        = 3'd4,
    ST_DISCONNECTING = 3'd5,
    ST_DISC_PENDING  = 3'd6
  } conn_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DECIDE,
    C_EMIT
  } ctl_state_t;

  localparam logic [3:0] REG_PLCI   = 4'd0;
  localparam logic [3:0] REG_APPL   = 4'd1;
  localparam logic [3:0] REG_WINDOW = 4'd2;

  localparam logic [15:0] INFO_EST_LIMIT = 16'h1000;
  localparam logic [7:0]  HLEN_SHORT     = 8'd22;
  localparam logic [7:0]  HLEN_LONG      = 8'd30;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] info;
    logic [15:0] msg_id;
    logic [15:0] handle;
    logic [2:0]  tag;
    logic [15:0] length;
    logic        layer1;
  } result_t;

  // datapath -> controller: decided plan for the latched event
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } plan_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic commit;
  } cmd_t;

endpackage

>>> hw/rtl/capi_b3_datapath.sv
module capi_b3_datapath #(
  parameter int WINDOW_SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  capi_b3_pkg::cmd_t    cmd,
  input  logic [3:0]           mode,
  input  logic [15:0]          info,
  input  logic [15:0]          msg_id,
  input  logic [15:0]          data_handle,
  input  logic [2:0]           tag,
  input  logic [7:0]           header_length,
  input  logic [15:0]          data_length,
  input  logic [3:0]           window_size,
  output capi_b3_pkg::plan_t   plan,
  output logic [2:0]           conn_state_now
);
  import capi_b3_pkg::*;

  localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  logic [3:0]  e_mode;
  logic [15:0] e_info, e_mid, e_handle, e_dlen;
  logic [2:0]  e_tag;
  logic [7:0]  e_hlen;

  conn_t       conn_state, conn_state_next;
  logic [15:0] msg_counter, msg_counter_next;
  logic [WINDOW_SLOTS-1:0] xmit_busy, xmit_busy_next, recv_busy, recv_busy_next;
  logic [15:0] xmit_handle [WINDOW_SLOTS];
  logic [15:0] xmit_msgid  [WINDOW_SLOTS];
  logic        xmit_wr;
  logic [SW-1:0] xmit_wr_slot;

  logic [4:0]  eff_win;
  logic        x_found, r_found;
  logic [SW-1:0] x_slot, r_slot, tag_slot;
  logic        tag_ok;
  logic [15:0] tag_wide;
  result_t     rz;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_mode <= mode; e_info <= info; e_mid <= msg_id; e_handle <= data_handle;
      e_tag <= tag; e_hlen <= header_length; e_dlen <= data_length;
    end
    if (xmit_wr) begin
      xmit_handle[xmit_wr_slot] <= e_handle;
      xmit_msgid[xmit_wr_slot]  <= e_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state <= ST_IDLE;
      msg_counter <= '0;
      xmit_busy <= '0;
      recv_busy <= '0;
    end else if (cmd.commit) begin
      conn_state <= conn_state_next;
      msg_counter <= msg_counter_next;
      xmit_busy <= xmit_busy_next;
      recv_busy <= recv_busy_next;
    end
  end

  always_comb begin
    eff_win = ({1'b0, window_size} > 5'(WINDOW_SLOTS)) ? 5'(WINDOW_SLOTS)
                                                        : {1'b0, window_size};
    x_found = 1'b0; x_slot = '0;
    r_found = 1'b0; r_slot = '0;
    for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
      if (!xmit_busy[i] && 5'(i) < eff_win) begin
        x_found = 1'b1; x_slot = SW'(i);
      end
      if (!recv_busy[i]) begin
        r_found = 1'b1; r_slot = SW'(i);
      end
    end
    tag_wide = {13'd0, e_tag};
    tag_slot = SW'(e_tag);
    tag_ok = ({2'b0, e_tag} < eff_win) && (tag_wide < 16'(WINDOW_SLOTS))
             && xmit_busy[tag_slot];
  end

  always_comb begin
    rz = '0;
    plan = '0;
    plan.r0 = rz; plan.r1 = rz; plan.r2 = rz;
    conn_state_next = conn_state;
    msg_counter_next = msg_counter;
    xmit_busy_next = xmit_busy;
    recv_busy_next = recv_busy;
    xmit_wr = 1'b0;
    xmit_wr_slot = x_slot;
    unique case (mode_t'(e_mode))
      M_CONN_REQ: begin
        if (conn_state != ST_IDLE) begin
          plan.count = 2'd1; plan.r0.kind = K_REJECT; plan.r0.msg_id = e_mid;
        end else if (e_info == 16'd0) begin
          conn_state_next = ST_WAIT;
          plan.count = 2'd2;
          plan.r0.kind = K_CONN_CONF; plan.r0.info = e_info; plan.r0.msg_id = e_mid;
          plan.r1.kind = K_DL_EST_REQ;
        end else begin
          plan.r0.kind = K_RELEASE;
          plan.r1.kind = K_CONN_CONF; plan.r1.info = e_info; plan.r1.msg_id = e_mid;
          plan.r2.kind = K_DL_EST_REQ;
          plan.count = (e_info < INFO_EST_LIMIT) ? 2'd3 : 2'd2;
        end
      end
      M_CONN_RESP: begin
        if (conn_state == ST_INCOMING) begin
          plan.count = 2'd1; plan.r0.msg_id = msg_counter;
          msg_counter_next = msg_counter + 16'd1;
          if (e_info == 16'd0) begin
            plan.r0.kind = K_ACTIVE_IND; conn_state_next = ST_ACTIVE;
            xmit_busy_next = '0; recv_busy_next = '0;
          end else begin
            plan.r0.kind = K_DISC_IND; conn_state_next = ST_DISC_PENDING;
          end
        end
      end
      M_DISC_REQ: begin
        if (conn_state == ST_INCOMING || conn_state == ST_WAIT || conn_state == ST_ACTIVE)
        begin
          conn_state_next = ST_DISCONNECTING;
          plan.count = 2'd2;
          plan.r0.kind = K_DISC_CONF; plan.r0.msg_id = e_mid;
          plan.r1.kind = K_DL_REL_REQ;
        end else begin
          plan.count = 2'd1; plan.r0.kind = K_REJECT; plan.r0.msg_id = e_mid;
        end
      end
      M_DISC_RESP: begin
        if (conn_state == ST_DISC_PENDING) begin
          conn_state_next = ST_IDLE;
          plan.count = 2'd1; plan.r0.kind = K_RELEASE;
        end
      end
      M_DATA_REQ: begin
        plan.count = 2'd1;
        if (conn_state != ST_ACTIVE) begin
          plan.r0.kind = K_REJECT; plan.r0.msg_id = e_mid;
        end else if ((e_hlen != HLEN_SHORT && e_hlen != HLEN_LONG) || !x_found) begin
          plan.r0.kind = K_ERROR;
        end else begin
          xmit_busy_next[x_slot] = 1'b1;
          xmit_wr = cmd.commit;
          plan.r0.kind = K_DL_DATA_REQ; plan.r0.msg_id = e_mid;
          plan.r0.handle = e_handle; plan.r0.tag = 3'(x_slot);
        end
      end
      M_DATA_RESP: begin
        if (e_handle >= 16'(WINDOW_SLOTS) || !recv_busy[SW'(e_handle)]) begin
          plan.count = 2'd1; plan.r0.kind = K_ERROR;
        end else begin
          recv_busy_next[SW'(e_handle)] = 1'b0;
        end
      end
      M_DL_DATA_IND: begin
        if (conn_state == ST_ACTIVE) begin
          plan.count = 2'd1;
          if (!r_found) begin
            plan.r0.kind = K_ERROR;
          end else begin
            recv_busy_next[r_slot] = 1'b1;
            msg_counter_next = msg_counter + 16'd1;
            plan.r0.kind = K_DATA_IND; plan.r0.msg_id = msg_counter;
            plan.r0.handle = 16'(r_slot); plan.r0.length = e_dlen;
          end
        end
      end
      M_DL_DATA_CNF: begin
        if (conn_state == ST_ACTIVE) begin
          plan.count = 2'd1;
          if (!tag_ok) begin
            plan.r0.kind = K_ERROR;
          end else begin
            xmit_busy_next[tag_slot] = 1'b0;
            plan.r0.kind = K_DATA_CONF; plan.r0.msg_id = xmit_msgid[tag_slot];
            plan.r0.handle = xmit_handle[tag_slot]; plan.r0.tag = e_tag;
          end
        end
      end
      M_DL_EST_IND, M_DL_EST_CNF: begin
        if (conn_state == ST_IDLE) begin
          plan.count = 2'd1; plan.r0.kind = K_CONN_IND; plan.r0.msg_id = msg_counter;
          msg_counter_next = msg_counter + 16'd1;
          conn_state_next = ST_INCOMING;
        end else if (mode_t'(e_mode) == M_DL_EST_CNF && conn_state == ST_WAIT) begin
          plan.count = 2'd1; plan.r0.kind = K_ACTIVE_IND; plan.r0.msg_id = msg_counter;
          msg_counter_next = msg_counter + 16'd1;
          conn_state_next = ST_ACTIVE;
          xmit_busy_next = '0; recv_busy_next = '0;
        end
      end
      M_DL_REL_IND, M_DL_REL_CNF, M_DL_DOWN: begin
        if ((mode_t'(e_mode) == M_DL_REL_IND &&
             (conn_state == ST_WAIT || conn_state == ST_ACTIVE)) ||
            (mode_t'(e_mode) == M_DL_REL_CNF && conn_state == ST_DISCONNECTING) ||
            (mode_t'(e_mode) == M_DL_DOWN &&
             (conn_state == ST_ACTIVE || conn_state == ST_DISCONNECTING))) begin
          plan.count = 2'd1; plan.r0.kind = K_DISC_IND; plan.r0.msg_id = msg_counter;
          plan.r0.layer1 = (mode_t'(e_mode) == M_DL_DOWN);
          msg_counter_next = msg_counter + 16'd1;
          conn_state_next = ST_DISC_PENDING;
        end
      end
      M_OTHER_REQ: begin
        plan.count = 2'd1; plan.r0.kind = K_REJECT; plan.r0.msg_id = e_mid;
      end
      default: ;
    endcase
  end

  assign conn_state_now = conn_state;

endmodule

>>> hw/rtl/capi_b3_ctrl.sv
module capi_b3_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  capi_b3_pkg::plan_t   plan,
  input  logic [2:0]           conn_state_now,
  output capi_b3_pkg::cmd_t    cmd,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [79:0]          m_axis_tdata,
  output logic                 m_axis_tlast
);
  import capi_b3_pkg::*;

  ctl_state_t state, state_next;
  result_t    q [3];
  logic [1:0] cnt, idx;
  result_t    cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      idx <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == C_DECIDE) begin
        cnt <= plan.count;
        idx <= '0;
      end else if (state == C_EMIT && m_axis_tready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  // latch results of the event
  always_ff @(posedge clk) begin
    if (state == C_DECIDE) begin
      q[0] <= plan.r0; q[1] <= plan.r1; q[2] <= plan.r2;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = (state == C_IDLE);
    unique case (state)
      C_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = C_DECIDE;
      end
      C_DECIDE: begin
        cmd.commit = 1'b1;
        state_next = (plan.count == 2'd0) ? C_IDLE : C_EMIT;
      end
      C_EMIT: if (m_axis_tready && idx + 2'd1 == cnt) state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  assign cur = q[idx];
  assign m_axis_tvalid = (state == C_EMIT);
  assign m_axis_tlast  = (idx + 2'd1 == cnt);
  // after commit the datapath state already holds the new connection state
  assign m_axis_tdata = {5'd0, conn_state_now, cur.layer1, cur.length, cur.tag,
                         cur.handle, cur.msg_id, cur.info, cur.kind};

endmodule

>>> hw/rtl/capi_b3_connection_controller_core.sv
// B3 connection controller. Each input word is one event (mode in tuser, the
// other fields packed in tdata); the block answers with zero to three result
// words, tlast on the final one. An event is decided and committed in the
// datapath in the decide state; results go out one per cycle while the output
// is ready; a new event is taken only after all results of the previous one
// are gone. Configuration writes via the cfg channel are taken at once.
module capi_b3_connection_controller_core #(
  parameter int WINDOW_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // info[15:0], msg_id[31:16], data_handle[47:32], tag[50:48],
  // header_length[58:51], data_length[74:59], zero fill
  input  logic [79:0] s_axis_tdata,
  input  logic [3:0]  s_axis_tuser,    // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // kind[3:0], out_info[19:4], out_msg_id[35:20], out_handle[51:36],
  // out_tag[54:52], out_length[70:55], layer1_reason[71],
  // conn_state_now[74:72], zero fill
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import capi_b3_pkg::*;

  logic [15:0] plci_address, appl_id;
  logic [3:0]  window_size;
  plan_t       plan;
  cmd_t        cmd;
  logic [2:0]  conn_state_now;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plci_address <= '0;
      appl_id <= '0;
      window_size <= 4'd8;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PLCI) plci_address <= cfg_data;
      if (cfg_index == REG_APPL) appl_id <= cfg_data;
      if (cfg_index == REG_WINDOW) window_size <= cfg_data[3:0];
    end
  end

  capi_b3_datapath #(.WINDOW_SLOTS(WINDOW_SLOTS)) u_dp (
    .clk, .rst, .cmd,
    .mode(s_axis_tuser),
    .info(s_axis_tdata[15:0]),
    .msg_id(s_axis_tdata[31:16]),
    .data_handle(s_axis_tdata[47:32]),
    .tag(s_axis_tdata[50:48]),
    .header_length(s_axis_tdata[58:51]),
    .data_length(s_axis_tdata[74:59]),
    .window_size,
    .plan,
    .conn_state_now
  );

  capi_b3_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .plan,
    .conn_state_now,
    .cmd,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

endmodule

>>> hw/rtl/capi_b3_checker.sv
module capi_b3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import capi_b3_pkg::*;

  // no new event is taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");

  // an accepted event is never answered in the very next cycle
  a_decide: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("early result");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'(K_ERROR)) else $error("bad kind");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output dropped");

endmodule

bind capi_b3_connection_controller_core capi_b3_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast
);
